// ----- sv/tft_pkg.sv -----
// Shared types and constants for the TCP flow table tracker.
// No dependencies; imported by every module of the block.
package tft_pkg;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_MOD    = 8'b0000_0100,
    S_RDV    = 8'b0000_1000,
    S_SCAN   = 8'b0001_0000,
    S_DECIDE = 8'b0010_0000,
    S_DUR    = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  localparam logic [1:0] ST_UPDATED = 2'd0;
  localparam logic [1:0] ST_CLOSED  = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  // FIN (bit 0) or RST (bit 2) closes a flow
  localparam logic [7:0] CLOSE_MASK = 8'h05;

  localparam int MS_PER_S  = 1000;
  localparam int US_PER_MS = 1000;
  // floor(2^30 / 1000): quotient estimate is exact or one short
  localparam logic [20:0] RECIP_K     = 21'd1073741;
  localparam int          RECIP_SHIFT = 30;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [63:0] addrs;     // source high, destination low
    logic [31:0] ports;     // source port high
    logic [31:0] packets;
    logic [31:0] start_s;
    logic [19:0] start_us;
  } entry_t;

endpackage

// ----- sv/tcp_flow_table_tracker_top.sv -----
// Top level of the TCP flow table tracker: sequencer, hashing, way scan.
// Depends on tft_pkg, tft_table and tft_lifetime.
//
//  Channel | Direction | Handshake             | Payload
//  in_     | input     | in_valid / in_ready   | tuple, timestamp, tcp flags
//  out_    | output    | out_valid / out_ready | status, tuple, count, duration
//
// One packet passes the idle, bucket read, way scan, decide and output states
// plus result wait; a close adds the wait for the lifetime unit; a bucket count
// that is not a power of two adds the reciprocal-multiply remainder steps.
// The single data memory read port, one way per cycle, sets the scan length.
// After reset a clearing pass over all BUCKET_COUNT buckets empties the valid
// rows; in_ready stays low until it ends. in_ready is high only while idle.
module tcp_flow_table_tracker_top import tft_pkg::*; #(
  parameter int BUCKET_COUNT = 1024,
  parameter int WAYS         = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_source_address,
  input  logic [31:0] in_dest_address,
  input  logic [15:0] in_source_port,
  input  logic [15:0] in_dest_port,
  input  logic [31:0] in_time_seconds,
  input  logic [19:0] in_time_micros,
  input  logic [7:0]  in_tcp_flags,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_report_source_address,
  output logic [31:0] out_report_dest_address,
  output logic [15:0] out_report_source_port,
  output logic [15:0] out_report_dest_port,
  output logic [31:0] out_packet_count,
  output logic [31:0] out_duration_ms
);

  localparam int  BW       = $clog2(BUCKET_COUNT);
  localparam int  AW       = $clog2(BUCKET_COUNT * WAYS);
  localparam int  WW       = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam bit  BKT_POW2 = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;
  // floor(2^32 / BUCKET_COUNT): quotient estimate is exact or one short
  localparam logic [31:0] BKT_RECIP = 32'(64'h1_0000_0000 / 64'(BUCKET_COUNT));

  state_t state_r, state_nxt;

  logic [31:0] sa_r, da_r, ts_r;
  logic [15:0] sp_r, dp_r;
  logic [19:0] tu_r;
  logic [7:0]  fl_r;
  logic [31:0] hash_r;
  logic [63:0]   mprod_r;
  logic [BW:0]   mrem_r;
  logic [1:0]    mstep_r;
  logic [BW-1:0] bucket_r, clr_r;
  logic [WW-1:0] way_r, hit_way_r, free_way_r;
  logic [AW-1:0] cur_addr_r, hit_addr_r, free_addr_r;
  logic          hit_r, free_r;
  logic [31:0]   hit_pk_r, hit_ss_r;
  logic [19:0]   hit_su_r;
  logic [1:0]    o_status_r;
  logic [31:0]   o_count_r, o_dur_r;

  logic [31:0]   hash;
  logic [AW-1:0] base;
  logic          last_way, vbit, match, found, closing;
  logic [AW-1:0] sel_addr;
  logic [WW-1:0] sel_way;
  logic [31:0]   new_pk, st_s;
  logic [19:0]   st_us;

  logic            v_we, v_re, d_we, d_re;
  logic [BW-1:0]   v_waddr;
  logic [WAYS-1:0] v_wdata, v_rdata, new_row;
  logic [AW-1:0]   d_raddr;
  entry_t          d_wdata, d_rdata;
  logic            lt_start, lt_done;
  logic [31:0]     lt_ms;

  always_comb begin
    hash     = in_source_address ^ in_dest_address ^ {in_source_port, in_dest_port};
    base     = AW'(bucket_r) * AW'(WAYS);
    last_way = (way_r == WW'(WAYS - 1));
    vbit     = v_rdata[way_r];
    match    = vbit && (d_rdata.addrs == {sa_r, da_r}) && (d_rdata.ports == {sp_r, dp_r});
    found    = hit_r || free_r;
    closing  = |(fl_r & CLOSE_MASK);
    sel_addr = hit_r ? hit_addr_r : free_addr_r;
    sel_way  = hit_r ? hit_way_r : free_way_r;
    new_pk   = hit_r ? ((hit_pk_r == COUNT_MAX) ? COUNT_MAX : hit_pk_r + 32'd1) : 32'd1;
    st_s     = hit_r ? hit_ss_r : ts_r;
    st_us    = hit_r ? hit_su_r : tu_r;
    new_row  = v_rdata;
    new_row[sel_way] = !closing;
  end

  // memory port control
  always_comb begin
    v_re    = (state_r == S_RDV);
    d_re    = (state_r == S_RDV) || ((state_r == S_SCAN) && !last_way);
    d_raddr = (state_r == S_RDV) ? base : cur_addr_r + AW'(1);
    v_we    = (state_r == S_CLEAR) || ((state_r == S_DECIDE) && found);
    v_waddr = (state_r == S_CLEAR) ? clr_r : bucket_r;
    v_wdata = (state_r == S_CLEAR) ? '0 : new_row;
    d_we    = (state_r == S_DECIDE) && found;
    d_wdata.addrs    = {sa_r, da_r};
    d_wdata.ports    = {sp_r, dp_r};
    d_wdata.packets  = new_pk;
    d_wdata.start_s  = st_s;
    d_wdata.start_us = st_us;
    lt_start = (state_r == S_DECIDE) && found && closing;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:  if (clr_r == BW'(BUCKET_COUNT - 1)) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = BKT_POW2 ? S_RDV : S_MOD;
      S_MOD:    if (mstep_r == 2'd2) state_nxt = S_RDV;
      S_RDV:    state_nxt = S_SCAN;
      S_SCAN:   if (last_way) state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = (found && closing) ? S_DUR : S_OUT;
      S_DUR:    if (lt_done) state_nxt = S_OUT;
      S_OUT:    if (out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + BW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        sa_r   <= in_source_address;
        da_r   <= in_dest_address;
        sp_r   <= in_source_port;
        dp_r   <= in_dest_port;
        ts_r   <= in_time_seconds;
        tu_r   <= in_time_micros;
        fl_r   <= in_tcp_flags;
        hash_r <= hash;
        mstep_r  <= '0;
        bucket_r <= hash[BW-1:0];
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end
      S_MOD: begin
        // estimate the quotient, subtract, then correct once
        case (mstep_r)
          2'd0: mprod_r <= 64'(hash_r) * 64'(BKT_RECIP);
          2'd1: mrem_r  <= (BW + 1)'(hash_r - mprod_r[63:32] * 32'(BUCKET_COUNT));
          default: begin
            bucket_r <= (mrem_r >= (BW + 1)'(BUCKET_COUNT)) ?
                        BW'(mrem_r - (BW + 1)'(BUCKET_COUNT)) : BW'(mrem_r);
          end
        endcase
        mstep_r <= mstep_r + 2'd1;
      end
      S_RDV: begin
        cur_addr_r <= base;
        way_r      <= '0;
      end
      S_SCAN: begin
        if (match && !hit_r) begin
          hit_r      <= 1'b1;
          hit_addr_r <= cur_addr_r;
          hit_way_r  <= way_r;
          hit_pk_r   <= d_rdata.packets;
          hit_ss_r   <= d_rdata.start_s;
          hit_su_r   <= d_rdata.start_us;
        end
        if (!vbit && !free_r) begin
          free_r      <= 1'b1;
          free_addr_r <= cur_addr_r;
          free_way_r  <= way_r;
        end
        if (!last_way) begin
          cur_addr_r <= cur_addr_r + AW'(1);
          way_r      <= way_r + WW'(1);
        end
      end
      S_DECIDE: begin
        o_dur_r <= '0;
        if (!found) begin
          o_status_r <= ST_DROPPED;
          o_count_r  <= '0;
        end else begin
          o_status_r <= closing ? ST_CLOSED : ST_UPDATED;
          o_count_r  <= new_pk;
        end
      end
      S_DUR: begin
        if (lt_done) begin
          o_dur_r <= lt_ms;
        end
      end
      default: begin
      end
    endcase
  end

  tft_table #(
    .BUCKET_COUNT(BUCKET_COUNT),
    .WAYS        (WAYS),
    .BW          (BW),
    .AW          (AW)
  ) u_table (
    .clk     (clk),
    .v_we    (v_we),
    .v_waddr (v_waddr),
    .v_wdata (v_wdata),
    .v_re    (v_re),
    .v_raddr (bucket_r),
    .v_rdata (v_rdata),
    .d_we    (d_we),
    .d_waddr (sel_addr),
    .d_wdata (d_wdata),
    .d_re    (d_re),
    .d_raddr (d_raddr),
    .d_rdata (d_rdata)
  );

  tft_lifetime u_lifetime (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lt_start),
    .now_s  (ts_r),
    .now_us (tu_r),
    .st_s   (st_s),
    .st_us  (st_us),
    .done   (lt_done),
    .ms     (lt_ms)
  );

  assign in_ready                  = (state_r == S_IDLE);
  assign out_valid                 = (state_r == S_OUT);
  assign out_status                = o_status_r;
  assign out_report_source_address = sa_r;
  assign out_report_dest_address   = da_r;
  assign out_report_source_port    = sp_r;
  assign out_report_dest_port      = dp_r;
  assign out_packet_count          = o_count_r;
  assign out_duration_ms           = o_dur_r;

endmodule

// ----- sv/tft_table.sv -----
// Flow table storage: per-bucket valid rows and per-way entry records.
// Depends on tft_pkg for the entry record type.
module tft_table import tft_pkg::*; #(
  parameter int BUCKET_COUNT = 1024,
  parameter int WAYS         = 4,
  parameter int BW           = $clog2(BUCKET_COUNT),
  parameter int AW           = $clog2(BUCKET_COUNT * WAYS)
) (
  input  logic            clk,
  input  logic            v_we,
  input  logic [BW-1:0]   v_waddr,
  input  logic [WAYS-1:0] v_wdata,
  input  logic            v_re,
  input  logic [BW-1:0]   v_raddr,
  output logic [WAYS-1:0] v_rdata,
  input  logic            d_we,
  input  logic [AW-1:0]   d_waddr,
  input  entry_t          d_wdata,
  input  logic            d_re,
  input  logic [AW-1:0]   d_raddr,
  output entry_t          d_rdata
);

  logic [WAYS-1:0] vmem [BUCKET_COUNT];
  entry_t          dmem [BUCKET_COUNT * WAYS];

  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[v_waddr] <= v_wdata;
    end
    if (v_re) begin
      v_rdata <= vmem[v_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dmem[d_waddr] <= d_wdata;
    end
    if (d_re) begin
      d_rdata <= dmem[d_raddr];
    end
  end

endmodule

// ----- sv/tft_lifetime.sv -----
// Three-stage flow lifetime unit: seconds and microseconds to saturated ms.
// Depends on tft_pkg for the scaling constants.
module tft_lifetime import tft_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] now_s,
  input  logic [19:0] now_us,
  input  logic [31:0] st_s,
  input  logic [19:0] st_us,
  output logic        done,
  output logic [31:0] ms
);

  logic [2:0]         v_r;
  logic signed [32:0] ds;
  logic signed [20:0] du;
  logic [19:0]        n;
  logic               neg_r, neg2_r;
  logic [19:0]        n_r;
  logic [40:0]        prod_r;
  logic signed [43:0] dsms_r, dsms2_r;
  logic [10:0]        q0;
  logic [10:0]        q0_r;
  logic [20:0]        r_r;
  logic [11:0]        q;
  logic signed [43:0] sq;
  logic signed [43:0] sum;
  logic [31:0]        ms_r;

  always_comb begin
    ds = $signed({1'b0, now_s}) - $signed({1'b0, st_s});
    du = $signed({1'b0, now_us}) - $signed({1'b0, st_us});
    n  = du[20] ? 20'(-du) : 20'(du);
    q0 = 11'(prod_r >> RECIP_SHIFT);
    q  = 12'(q0_r) + 12'(r_r >= 21'(US_PER_MS));
    sq = neg2_r ? -$signed(44'(q)) : $signed(44'(q));
    sum = dsms2_r + sq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: differences and products
    neg_r  <= du[20];
    n_r    <= n;
    prod_r <= 41'(n) * 41'(RECIP_K);
    dsms_r <= 44'(ds) * 44'(MS_PER_S);
    // stage 2: quotient estimate and remainder
    q0_r    <= q0;
    r_r     <= 21'(n_r) - 21'(q0) * 21'(US_PER_MS);
    neg2_r  <= neg_r;
    dsms2_r <= dsms_r;
    // stage 3: correct, combine, saturate
    if (sum < 0) begin
      ms_r <= '0;
    end else if (sum > $signed(44'(COUNT_MAX))) begin
      ms_r <= COUNT_MAX;
    end else begin
      ms_r <= sum[31:0];
    end
  end

  assign done = v_r[2];
  assign ms   = ms_r;

endmodule

// ----- sv/tft_checker.sv -----
// Port-level checks for the TCP flow table tracker, bound to the top level.
// Depends on tft_pkg for the status codes.
module tft_checker import tft_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_packet_count,
  input logic [31:0] out_duration_ms
);

  // one packet in flight: never take a transfer while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while result pending");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_UPDATED || out_status == ST_CLOSED ||
                   out_status == ST_DROPPED))
    else $error("undefined status code");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_DROPPED) |->
      (out_packet_count == 32'd0 && out_duration_ms == 32'd0))
    else $error("dropped packet carries count or duration");

  a_update_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_UPDATED) |->
      (out_packet_count != 32'd0 && out_duration_ms == 32'd0))
    else $error("update result has bad count or duration");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) &&
                                   $stable(out_packet_count)))
    else $error("stalled result changed");

endmodule

bind tcp_flow_table_tracker_top tft_checker u_tft_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_packet_count (out_packet_count),
  .out_duration_ms  (out_duration_ms)
);
